/* hdl/vcap_pkg.sv */
// ----------------------------------------------------------------------------
// vcap_pkg
// Shared types and constants of the voxel cave automaton pass: hash constants,
// hash step codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package vcap_pkg;

    // hash finalizer and spatial hash constants
    localparam logic [31:0] FmixC1 = 32'h85eb_ca6b;
    localparam logic [31:0] FmixC2 = 32'hc2b2_ae35;
    localparam logic [31:0] HashCx = 32'd73856093;
    localparam logic [31:0] HashCy = 32'd19349663;
    localparam logic [31:0] HashCz = 32'd83492791;

    // solid when more than this many neighbours are solid
    localparam logic [4:0] NbrThresh = 5'd13;

    // cycles the derived size registers need after a register write
    localparam logic [2:0] SettleCycles = 3'd4;

    typedef logic [3:0] t_hstep;
    localparam t_hstep HashSteps = 4'd13;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_SIZE_X = 3'd1,
        CFG_SIZE_Y = 3'd2,
        CFG_SIZE_Z = 3'd3,
        CFG_SEED   = 3'd4,
        CFG_THRESH = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        HOP_SEED = 4'd0,
        HOP_MUL1 = 4'd1,
        HOP_XS13 = 4'd2,
        HOP_MUL2 = 4'd3,
        HOP_SAVE = 4'd4,
        HOP_MX   = 4'd5,
        HOP_MY   = 4'd6,
        HOP_MZ   = 4'd7,
        HOP_XS16 = 4'd8
    } t_hop;

    // operation of each hash step: fmix(seed), then fmix of the mixed coordinate
    function automatic t_hop hash_op(input t_hstep step);
        t_hop op;
        case (step)
            4'd0:    op = HOP_SEED;
            4'd1:    op = HOP_MUL1;
            4'd2:    op = HOP_XS13;
            4'd3:    op = HOP_MUL2;
            4'd4:    op = HOP_SAVE;
            4'd5:    op = HOP_MX;
            4'd6:    op = HOP_MY;
            4'd7:    op = HOP_MZ;
            4'd8:    op = HOP_XS16;
            4'd9:    op = HOP_MUL1;
            4'd10:   op = HOP_XS13;
            4'd11:   op = HOP_MUL2;
            default: op = HOP_XS16;
        endcase
        return op;
    endfunction

    typedef struct packed {
        logic   accept;
        logic   hash_en;
        t_hstep hash_step;
        logic   nbr_en;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic warm;
        logic settled;
        logic nbr_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/vcap_ctrl.sv */
// ----------------------------------------------------------------------------
// vcap_ctrl
// Sequencer of the pass: accepts an item, steps the hash or walks the
// 27 window positions, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcap_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  vcap_pkg::t_sts      i_sts,
    output vcap_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_NBR   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    vcap_pkg::t_hstep      r_step, n_step;
    logic                  c_accept;

    assign c_accept   = (r_state == S_IDLE) && i_sts.settled && i_in_valid;
    assign o_in_stall = !((r_state == S_IDLE) && i_sts.settled);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.accept    = c_accept;
        o_cmd.hash_step = r_step;
        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_step = '0;
                    if (!i_sts.mode) begin
                        n_state = S_HASH;
                    end else if (!i_sts.warm) begin
                        n_state = S_NBR;
                    end
                end
            end
            S_HASH: begin
                o_cmd.hash_en = 1'b1;
                if (r_step == vcap_pkg::HashSteps - 4'd1) begin
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_NBR: begin
                o_cmd.nbr_en = 1'b1;
                if (i_sts.nbr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

/* hdl/vcap_dp.sv */
// ----------------------------------------------------------------------------
// vcap_dp
// Datapath of the pass: registers, derived sizes, raster counters, the
// shared hash multiplier, the window memory with its neighbour counter and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcap_dp #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr,
    input  wire  [2:0]          i_cfg_idx,
    input  wire  [31:0]         i_cfg_data,
    input  wire                 i_cell_in,
    input  vcap_pkg::t_cmd      i_cmd,
    output vcap_pkg::t_sts      o_sts,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    output logic                o_cell_out,
    output logic [7:0]          o_out_x,
    output logic [7:0]          o_out_y,
    output logic [7:0]          o_out_z,
    output logic                o_last
);

    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int ZW    = $clog2(MAX_Z);
    localparam int SXW   = $clog2(MAX_X + 1);
    localparam int SYW   = $clog2(MAX_Y + 1);
    localparam int SZW   = $clog2(MAX_Z + 1);
    localparam int PW    = SXW + SYW;
    localparam int TW    = PW + SZW;
    localparam int KW    = TW + 1;
    localparam int DEPTH = 2 * (MAX_X * MAX_Y + MAX_X + 1) + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = AW + 2;

    localparam logic [1:0] NbLo  = 2'd0;
    localparam logic [1:0] NbMid = 2'd1;
    localparam logic [1:0] NbHi  = 2'd2;

    // configuration registers
    logic              r_mode;
    logic [8:0]        r_size_x, r_size_y, r_size_z;
    logic [31:0]       r_seed;
    logic [24:0]       r_thr;
    logic [2:0]        r_settle;
    logic              c_cfg_ok;

    // derived sizes
    logic [SXW-1:0]    c_sx, r_sx;
    logic [SYW-1:0]    c_sy, r_sy;
    logic [SZW-1:0]    c_sz, r_sz;
    logic [PW-1:0]     r_plane;
    logic [AW-1:0]     r_lag, r_width;
    logic [TW-1:0]     r_total;

    // raster state
    logic [KW-1:0]     r_k;
    logic [AW-1:0]     r_wp, r_cp;
    logic [XW-1:0]     r_px;
    logic [YW-1:0]     r_py;
    logic [ZW-1:0]     r_pz;
    logic              c_in_grid, c_last, c_ex, c_ey, c_ez;

    // window
    logic              mem [DEPTH];
    logic              r_q, r_rd_vld;
    logic [1:0]        r_dx, r_dy, r_dz;
    logic [4:0]        r_count;
    logic signed [OW-1:0] c_ox, c_oy, c_oz, c_sum;
    logic [AW-1:0]     c_addr;
    logic              c_xok, c_yok, c_zok, c_center;

    // hash
    logic [31:0]       r_acc, r_fs, n_acc, c_ma, c_mb, c_prod;
    vcap_pkg::t_hop    c_hop;
    logic              c_fill_cell, c_cell;

    assign c_cfg_ok = (i_cfg_idx <= vcap_pkg::CFG_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_size_x <= 9'd1;
            r_size_y <= 9'd1;
            r_size_z <= 9'd1;
            r_seed   <= '0;
            r_thr    <= '0;
            r_settle <= vcap_pkg::SettleCycles;
        end else begin
            if (i_cfg_wr) begin
                r_settle <= vcap_pkg::SettleCycles;
                case (i_cfg_idx)
                    vcap_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                    vcap_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data[8:0];
                    vcap_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data[8:0];
                    vcap_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data[8:0];
                    vcap_pkg::CFG_SEED:   r_seed   <= i_cfg_data;
                    vcap_pkg::CFG_THRESH: r_thr    <= i_cfg_data[24:0];
                    default: ;
                endcase
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end
        end
    end

    // zero acts as one, oversize acts as the maximum
    assign c_sx = (r_size_x == 9'd0) ? SXW'(1) :
                  (32'(r_size_x) > 32'(MAX_X)) ? SXW'(MAX_X) : SXW'(r_size_x);
    assign c_sy = (r_size_y == 9'd0) ? SYW'(1) :
                  (32'(r_size_y) > 32'(MAX_Y)) ? SYW'(MAX_Y) : SYW'(r_size_y);
    assign c_sz = (r_size_z == 9'd0) ? SZW'(1) :
                  (32'(r_size_z) > 32'(MAX_Z)) ? SZW'(MAX_Z) : SZW'(r_size_z);

    always_ff @(posedge i_clk) begin
        r_sx    <= c_sx;
        r_sy    <= c_sy;
        r_sz    <= c_sz;
        r_plane <= PW'(r_sx) * PW'(r_sy);
        r_lag   <= AW'(r_plane) + AW'(r_sx) + AW'(1);
        r_total <= TW'(r_plane) * TW'(r_sz);
        r_width <= AW'({r_lag, 1'b1});
    end

    assign c_in_grid = 64'(r_k) < 64'(r_total);
    assign c_ex      = (32'(r_px) + 32'd1) == 32'(r_sx);
    assign c_ey      = (32'(r_py) + 32'd1) == 32'(r_sy);
    assign c_ez      = (32'(r_pz) + 32'd1) == 32'(r_sz);
    assign c_last    = c_ex && c_ey && c_ez;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_wp <= '0;
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
        end else if (i_cfg_wr && c_cfg_ok) begin
            r_k  <= '0;
            r_wp <= '0;
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
        end else if (i_cmd.emit && c_last) begin
            r_k  <= '0;
            r_wp <= '0;
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
        end else begin
            if (i_cmd.accept && r_mode) begin
                r_k  <= r_k + KW'(1);
                r_wp <= (r_wp == r_width - AW'(1)) ? '0 : r_wp + AW'(1);
            end
            if (i_cmd.emit) begin
                if (c_ex) begin
                    r_px <= '0;
                    if (c_ey) begin
                        r_py <= '0;
                        r_pz <= r_pz + ZW'(1);
                    end else begin
                        r_py <= r_py + YW'(1);
                    end
                end else begin
                    r_px <= r_px + XW'(1);
                end
            end
        end
    end

    // slot of the voxel being smoothed, lag items behind the write
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cp <= (r_wp >= r_lag) ? r_wp - r_lag : r_wp + r_width - r_lag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_mode) begin
            mem[r_wp] <= c_in_grid ? i_cell_in : 1'b0;
        end
        r_q <= mem[c_addr];
    end

    // neighbour walk
    assign c_ox = (r_dx == NbLo) ? -OW'(1) : (r_dx == NbHi) ? OW'(1) : '0;
    assign c_oy = (r_dy == NbLo) ? -OW'(r_sx) : (r_dy == NbHi) ? OW'(r_sx) : '0;
    assign c_oz = (r_dz == NbLo) ? -OW'(r_plane) : (r_dz == NbHi) ? OW'(r_plane) : '0;

    always_comb begin
        c_sum = OW'(r_cp) + c_ox + c_oy + c_oz;
        if (c_sum < 0) begin
            c_addr = AW'(c_sum + OW'(r_width));
        end else if (c_sum >= OW'(r_width)) begin
            c_addr = AW'(c_sum - OW'(r_width));
        end else begin
            c_addr = AW'(c_sum);
        end
    end

    assign c_xok = (r_dx == NbLo) ? (r_px != '0) :
                   (r_dx == NbHi) ? !c_ex : 1'b1;
    assign c_yok = (r_dy == NbLo) ? (r_py != '0) :
                   (r_dy == NbHi) ? !c_ey : 1'b1;
    assign c_zok = (r_dz == NbLo) ? (r_pz != '0) :
                   (r_dz == NbHi) ? !c_ez : 1'b1;
    assign c_center = (r_dx == NbMid) && (r_dy == NbMid) && (r_dz == NbMid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx     <= NbLo;
            r_dy     <= NbLo;
            r_dz     <= NbLo;
            r_rd_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_rd_vld <= i_cmd.nbr_en && c_xok && c_yok && c_zok && !c_center;
            if (i_cmd.accept) begin
                r_dx    <= NbLo;
                r_dy    <= NbLo;
                r_dz    <= NbLo;
                r_count <= '0;
            end else begin
                if (r_rd_vld) begin
                    r_count <= r_count + 5'(r_q);
                end
                if (i_cmd.nbr_en) begin
                    if (r_dx == NbHi) begin
                        r_dx <= NbLo;
                        if (r_dy == NbHi) begin
                            r_dy <= NbLo;
                            r_dz <= r_dz + 2'd1;
                        end else begin
                            r_dy <= r_dy + 2'd1;
                        end
                    end else begin
                        r_dx <= r_dx + 2'd1;
                    end
                end
            end
        end
    end

    // hash: one shared multiplier, one step a cycle
    assign c_hop = vcap_pkg::hash_op(i_cmd.hash_step);

    always_comb begin
        case (c_hop)
            vcap_pkg::HOP_MUL1: begin c_ma = r_acc;       c_mb = vcap_pkg::FmixC1; end
            vcap_pkg::HOP_MUL2: begin c_ma = r_acc;       c_mb = vcap_pkg::FmixC2; end
            vcap_pkg::HOP_MX:   begin c_ma = 32'(r_px);   c_mb = vcap_pkg::HashCx; end
            vcap_pkg::HOP_MY:   begin c_ma = 32'(r_py);   c_mb = vcap_pkg::HashCy; end
            vcap_pkg::HOP_MZ:   begin c_ma = 32'(r_pz);   c_mb = vcap_pkg::HashCz; end
            default:            begin c_ma = r_acc;       c_mb = 32'd1;            end
        endcase
        c_prod = c_ma * c_mb;
        case (c_hop)
            vcap_pkg::HOP_SEED: n_acc = r_seed ^ (r_seed >> 16);
            vcap_pkg::HOP_MUL1: n_acc = c_prod;
            vcap_pkg::HOP_MUL2: n_acc = c_prod;
            vcap_pkg::HOP_XS13: n_acc = r_acc ^ (r_acc >> 13);
            vcap_pkg::HOP_XS16: n_acc = r_acc ^ (r_acc >> 16);
            vcap_pkg::HOP_MX:   n_acc = c_prod;
            vcap_pkg::HOP_MY:   n_acc = r_acc ^ c_prod;
            vcap_pkg::HOP_MZ:   n_acc = r_acc ^ c_prod ^ r_fs;
            default:            n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_en) begin
            r_acc <= n_acc;
            if (c_hop == vcap_pkg::HOP_SAVE) begin
                r_fs <= r_acc ^ (r_acc >> 16);
            end
        end
    end

    assign c_fill_cell = 25'(r_acc[31:8]) < r_thr;
    assign c_cell      = r_mode ? (r_count > vcap_pkg::NbrThresh) : c_fill_cell;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_cell_out <= c_cell;
            o_out_x    <= 8'(r_px);
            o_out_y    <= 8'(r_py);
            o_out_z    <= 8'(r_pz);
            o_last     <= c_last;
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.warm     = 64'(r_k) < 64'(r_lag);
    assign o_sts.settled  = (r_settle == 3'd0);
    assign o_sts.nbr_last = (r_dx == NbHi) && (r_dy == NbHi) && (r_dz == NbHi);
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

endmodule

`default_nettype wire

/* hdl/voxel_cave_automaton_pass.sv */
// ----------------------------------------------------------------------------
// voxel_cave_automaton_pass
// One raster pass (x, then y, then z) of hash noise fill or 26-neighbour
// smoothing over a voxel grid.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall carries one voxel (i_cell_in)
//   output channel o_out_valid / i_out_stall carries the voxel, its coordinate
//   and o_last on the final voxel of the pass
//   registers are written through i_cfg_wr / i_cfg_idx / i_cfg_data while idle;
//   any register write restarts the pass
// Flow: fill mode runs the 13-step hash on one multiplier; the next item is
//   taken only once the result of the last is in the output register
//   smoothing mode: warm-up items are only written to the window memory;
//   others take the 27-position walk over the single read port of the
//   window memory, and the next item is taken only once the result is emitted
//   after a register write or reset, items are held off while the derived
//   sizes settle
// Stall: a waiting result sits in the output register while the next item is
// taken and worked on; the block then holds in its emit step until it drains.
// Reset clears registers and counters; the window memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_cave_automaton_pass #(
    parameter int MAX_X = 256,
    parameter int MAX_Y = 256,
    parameter int MAX_Z = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_cell_in,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_cell_out,
    output logic [7:0]  o_out_x,
    output logic [7:0]  o_out_y,
    output logic [7:0]  o_out_z,
    output logic        o_last
);

    vcap_pkg::t_cmd w_cmd;
    vcap_pkg::t_sts w_sts;

    vcap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    vcap_dp #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_wr),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cell_in   (i_cell_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cell_out  (o_cell_out),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

/* hdl/vcap_checker.sv */
// ----------------------------------------------------------------------------
// vcap_checker
// Port-level checks of the voxel cave automaton pass, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vcap_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_cfg_wr,
    input wire         o_in_stall,
    input wire         o_out_valid,
    input wire         i_out_stall,
    input wire         o_cell_out,
    input wire  [7:0]  o_out_x,
    input wire  [7:0]  o_out_y,
    input wire  [7:0]  o_out_z,
    input wire         o_last
);

    // derived sizes need time after a write before an item may enter
    a_cfg_holds_input: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) i_cfg_wr |=> o_in_stall)
        else $error("item taken right after a register write");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    a_out_hold: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled item dropped");

    a_out_stable: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_out_valid && i_out_stall |=>
        $stable(o_cell_out) && $stable(o_out_x) && $stable(o_out_y) &&
        $stable(o_out_z) && $stable(o_last))
        else $error("stalled item changed");

endmodule

bind voxel_cave_automaton_pass vcap_checker u_vcap_checker (.*);

`default_nettype wire
